FILE: sv/nbq_pkg.sv
`default_nettype none

package nbq_pkg;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_QUEUED  = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Input beat
  typedef struct packed {
    logic        cmd;
    logic [7:0]  device_id;
    logic        op_kind;
    logic [31:0] start_block;
    logic [31:0] block_count;
    logic [31:0] buffer_address;
    logic [31:0] head_position;
  } req_t;

  // Output beat
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [7:0]  out_device;
    logic        out_kind;
    logic [31:0] out_start_block;
    logic [31:0] out_block_count;
    logic [31:0] out_buffer_address;
  } rsp_t;

  // One stored request
  typedef struct packed {
    logic [7:0]  device;
    logic        kind;
    logic [31:0] block;
    logic [31:0] count;
    logic [31:0] buffer;
  } entry_t;

  // Sequencer control for the seek comparator
  typedef struct packed {
    logic clear;
    logic step;
  } cmp_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/nbq_if.sv
`default_nettype none

interface nbq_req_if;
  import nbq_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nbq_rsp_if;
  import nbq_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/nbq_entry_mem.sv
`default_nettype none

module nbq_entry_mem #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [IW-1:0]   wr_addr,
  input  wire nbq_pkg::entry_t wr_data,
  input  wire logic [IW-1:0]   rd_addr,
  output nbq_pkg::entry_t      rd_data
);
  import nbq_pkg::*;

  entry_t mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/nbq_seek_cmp.sv
`default_nettype none

module nbq_seek_cmp #(
  parameter int IW = 4,
  parameter int AW = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire nbq_pkg::cmp_ctrl_t ctrl,
  input  wire logic [31:0]        head,
  input  wire logic [31:0]        cand_block,
  input  wire logic               cand_valid,
  input  wire logic [IW-1:0]      cand_idx,
  input  wire logic [AW-1:0]      cand_age,
  output logic                    found,
  output logic [IW-1:0]           best_idx,
  output logic [AW-1:0]           best_age
);
  import nbq_pkg::*;

  logic [31:0] best_dist;
  logic [31:0] seek_dist;
  logic        take;

  // Absolute seek distance and running-best test (youngest wins a tie)
  always_comb begin
    seek_dist = (head > cand_block) ? (head - cand_block) : (cand_block - head);
    take = cand_valid &&
           (!found || (seek_dist < best_dist) ||
            ((seek_dist == best_dist) && (cand_age < best_age)));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      found <= 1'b0;
    end else if (ctrl.step && take) begin
      found <= 1'b1;
    end
    if (ctrl.step && take) begin
      best_idx  <= cand_idx;
      best_age  <= cand_age;
      best_dist <= seek_dist;
    end
  end

endmodule

`default_nettype wire

FILE: sv/nearest_block_request_queue_unit.sv
`default_nettype none

// Disk request queue with shortest-seek-first pick. An enqueue beat (cmd 0)
// stores its request in the lowest free slot and answers status 0 with that
// slot, or status 3 if all QUEUE_DEPTH slots are taken. A dequeue beat (cmd 1)
// removes the pending request whose start block is nearest to head_position
// (the most recently queued one on a tie) and returns it with status 1, or
// status 2 when the queue is empty. One beat is handled at a time: a dequeue
// walks every slot through one shared distance comparator, one slot per
// cycle, then reads out the nearest request from the entry memory and frees
// its slot; an enqueue walks the valid bits up to the first free slot. The
// result sits in an output register, so the next request can be accepted
// while it waits to be taken.
module nearest_block_request_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  nbq_req_if.sink     req,
  nbq_rsp_if.source   rsp
);
  import nbq_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int AW = IW;
  localparam logic [IW-1:0] IDX_LAST = IW'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0] AGE_MAX  = AW'(QUEUE_DEPTH - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FREE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]             state;
  logic [IW-1:0]          idx;
  req_t                   cur;
  rsp_t                   res;
  logic [QUEUE_DEPTH-1:0] valid;
  logic [AW-1:0]          age [QUEUE_DEPTH];

  logic                   cand_live;
  logic                   cand_valid;
  logic [IW-1:0]          cand_idx;
  logic [AW-1:0]          cand_age;

  cmp_ctrl_t              cmp_ctrl;
  logic                   found;
  logic [IW-1:0]          best_idx;
  logic [AW-1:0]          best_age;

  entry_t                 wr_data;
  entry_t                 rd_data;
  logic [IW-1:0]          rd_addr;
  logic                   enq_wr;
  logic                   deq_rm;
  logic                   accept;
  logic                   rsp_load;

  // Result with only status and slot set, data fields cleared
  function automatic rsp_t status_rsp(input logic [1:0] code, input logic [3:0] slot_num);
    rsp_t r;
    r = '0;
    r.status = code;
    r.slot = slot_num;
    return r;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp_load  = (state == S_DONE) && (!rsp.valid || rsp.ready);
  assign enq_wr    = (state == S_FREE) && !valid[idx];
  assign deq_rm    = (state == S_LOAD);
  assign rd_addr   = (state == S_FETCH) ? best_idx : idx;

  assign cmp_ctrl.clear = accept;
  assign cmp_ctrl.step  = cand_live;

  assign wr_data.device = cur.device_id;
  assign wr_data.kind   = cur.op_kind;
  assign wr_data.block  = cur.start_block;
  assign wr_data.count  = cur.block_count;
  assign wr_data.buffer = cur.buffer_address;

  nbq_entry_mem #(
    .DEPTH (QUEUE_DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (enq_wr),
    .wr_addr (idx),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nbq_seek_cmp #(
    .IW (IW),
    .AW (AW)
  ) u_cmp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (cmp_ctrl),
    .head       (cur.head_position),
    .cand_block (rd_data.block),
    .cand_valid (cand_valid),
    .cand_idx   (cand_idx),
    .cand_age   (cand_age),
    .found      (found),
    .best_idx   (best_idx),
    .best_age   (best_age)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cand_live <= 1'b0;
    end else begin
      cand_live <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur   <= req.data;
            idx   <= '0;
            state <= (req.data.cmd == CMD_DEQ) ? S_SCAN : S_FREE;
          end
        end
        S_FREE: begin
          if (!valid[idx]) begin
            res   <= status_rsp(ST_QUEUED, 4'(idx));
            state <= S_DONE;
          end else if (idx == IDX_LAST) begin
            res   <= status_rsp(ST_FULL, 4'd0);
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SCAN: begin
          cand_live  <= 1'b1;
          cand_idx   <= idx;
          cand_valid <= valid[idx];
          cand_age   <= age[idx];
          if (idx == IDX_LAST) begin
            state <= S_LAST;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_LAST: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (!found) begin
            res   <= status_rsp(ST_EMPTY, 4'd0);
            state <= S_DONE;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          res.status             <= ST_DEQUEUED;
          res.slot               <= 4'(best_idx);
          res.out_device         <= rd_data.device;
          res.out_kind           <= rd_data.kind;
          res.out_start_block    <= rd_data.block;
          res.out_block_count    <= rd_data.count;
          res.out_buffer_address <= rd_data.buffer;
          state                  <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Per-slot valid bits and ages; age 0 is the youngest pending request
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        age[i] <= '0;
      end
    end else if (enq_wr) begin
      valid[idx] <= 1'b1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (IW'(i) == idx) begin
          age[i] <= '0;
        end else if (valid[i] && (age[i] != AGE_MAX)) begin
          age[i] <= age[i] + 1'b1;
        end
      end
    end else if (deq_rm) begin
      valid[best_idx] <= 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (valid[i] && (age[i] > best_age)) begin
          age[i] <= age[i] - 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (rsp_load) begin
      rsp.data <= res;
    end
  end

endmodule

`default_nettype wire
